// ===== rtl/segment_clip_unit_cube_unit_defines.svh =====
// Assertion macros used by the checker file of the segment clipper.
`ifndef SEGMENT_CLIP_UNIT_CUBE_UNIT_DEFINES_SVH
`define SEGMENT_CLIP_UNIT_CUBE_UNIT_DEFINES_SVH

// Antecedent implies consequent, checked on every rising edge out of reset.
`define SCUC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scuc: implication check failed");

// Expression holds on every rising edge out of reset.
`define SCUC_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("scuc: invariant check failed");

`endif

// ===== rtl/scuc_pkg.sv =====
`default_nettype none

package scuc_pkg;

  // Field widths
  localparam int COORD_W             = 24;
  localparam int CHAN_W              = 12;
  localparam int RGB_W               = 3 * CHAN_W;
  localparam int COORD_FRAC_BITS_DEF = 16;

  // Datapath widths
  localparam int NUM_W   = COORD_W + 2;          // face numerators, room for 1.0 at 24 frac bits
  localparam int DEN_W   = COORD_W + 1;          // |end - start|
  localparam int DIFF_W  = COORD_W + 1;          // signed end - start
  localparam int PROD_W  = NUM_W + DEN_W + 1;    // cross products
  localparam int LERP_W  = DIFF_W + NUM_W;       // diff * numerator
  localparam int DIVX_W  = LERP_W + 2;           // 2 * p + d
  localparam int DIVY_W  = DEN_W + 1;            // 2 * d
  localparam int QUO_W   = COORD_W + 1;          // quotient magnitude bits

  // Pipeline shape
  localparam int DIV_STEPS    = 4;
  localparam int DIV_STAGES   = (QUO_W + DIV_STEPS - 1) / DIV_STEPS;
  localparam int FRONT_STAGES = 7;
  localparam int PIPE_LAT     = FRONT_STAGES + DIV_STAGES + 1;

  typedef struct packed {
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] start_z;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
    logic signed [COORD_W-1:0] end_z;
    logic        [RGB_W-1:0]   start_rgb;
    logic        [RGB_W-1:0]   end_rgb;
  } seg_in_t;

  typedef struct packed {
    logic                      seen;
    logic signed [COORD_W-1:0] clip_start_x;
    logic signed [COORD_W-1:0] clip_start_y;
    logic signed [COORD_W-1:0] clip_start_z;
    logic signed [COORD_W-1:0] clip_end_x;
    logic signed [COORD_W-1:0] clip_end_y;
    logic signed [COORD_W-1:0] clip_end_z;
    logic        [RGB_W-1:0]   clip_start_rgb;
    logic        [RGB_W-1:0]   clip_end_rgb;
  } seg_out_t;

endpackage

`default_nettype wire

// ===== rtl/scuc_div_pipe.sv =====
`default_nettype none

// Pipelined floor division of signed X by positive Y, STEPS quotient bits per stage.
module scuc_div_pipe #(
  parameter int LANES  = 12,
  parameter int X_W    = 53,
  parameter int Y_W    = 26,
  parameter int Q_W    = 25,
  parameter int STEPS  = 4,
  parameter int SIDE_W = 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic signed [X_W-1:0] in_x [LANES],
  input  logic [Y_W-1:0]      in_y [LANES],
  input  logic [SIDE_W-1:0]   in_side,
  output logic                out_valid,
  output logic signed [Q_W:0] out_q [LANES],
  output logic [SIDE_W-1:0]   out_side
);

  localparam int R_W = X_W - 1;
  localparam int NST = (Q_W + STEPS - 1) / STEPS;

  typedef struct packed {
    logic           neg;
    logic [Y_W-1:0] y;
    logic [R_W-1:0] rem;
    logic [Q_W-1:0] quo;
  } lane_t;

  lane_t             lane_r [NST][LANES];
  logic [NST-1:0]    vld_r;
  logic [SIDE_W-1:0] side_r [NST];

  for (genvar g = 0; g < NST; g++) begin : g_stage
    lane_t             cur [LANES];
    lane_t             nxt [LANES];
    logic              cur_v;
    logic [SIDE_W-1:0] cur_side;

    if (g == 0) begin : g_load
      // fold negative dividends: floor(X/Y) = ~floor(~X/Y)
      always_comb begin
        for (int l = 0; l < LANES; l++) begin
          cur[l].neg = in_x[l][X_W-1];
          cur[l].y   = in_y[l];
          cur[l].rem = in_x[l][X_W-1] ? ~in_x[l][R_W-1:0] : in_x[l][R_W-1:0];
          cur[l].quo = '0;
        end
      end
      assign cur_v    = in_valid;
      assign cur_side = in_side;
    end else begin : g_link
      assign cur      = lane_r[g-1];
      assign cur_v    = vld_r[g-1];
      assign cur_side = side_r[g-1];
    end

    // restoring steps, quotient MSB first
    always_comb begin
      logic [R_W-1:0] shd;
      int             k;
      nxt = cur;
      for (int l = 0; l < LANES; l++) begin
        for (int i = 0; i < STEPS; i++) begin
          if (g * STEPS + i < Q_W) begin
            k   = Q_W - 1 - (g * STEPS + i);
            shd = R_W'(nxt[l].y) << k;
            if (nxt[l].rem >= shd) begin
              nxt[l].rem    = nxt[l].rem - shd;
              nxt[l].quo[k] = 1'b1;
            end
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      lane_r[g] <= nxt;
      side_r[g] <= cur_side;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else begin
        vld_r[g] <= cur_v;
      end
    end
  end

  // unfold sign
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      out_q[l] = lane_r[NST-1][l].neg ? ~{1'b0, lane_r[NST-1][l].quo}
                                      : {1'b0, lane_r[NST-1][l].quo};
    end
  end

  assign out_valid = vld_r[NST-1];
  assign out_side  = side_r[NST-1];

endmodule

`default_nettype wire

// ===== rtl/segment_clip_unit_cube_unit.sv =====
`default_nettype none

// Channel  | Ports                      | Handshake
// ---------+----------------------------+------------------------------------
// request  | start, busy, in_req        | taken when start high and busy low
// result   | out_valid, out_res         | one-cycle strobe, no back-pressure
//
// One segment per cycle; busy stays low. A segment passes seven front stages
// (face bounds, two compare rounds, visibility and lerp products, divider
// operands), the seven-stage 4-bit-per-stage divider, the output register.
// Reset (synchronous, active low) clears only the stage valid bits.
// The receiver cannot stall, so the pipeline never holds.
module segment_clip_unit_cube_unit #(
  parameter int COORD_FRAC_BITS = scuc_pkg::COORD_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  scuc_pkg::seg_in_t  in_req,
  output logic               out_valid,
  output scuc_pkg::seg_out_t out_res
);

  import scuc_pkg::*;

  localparam int LANES  = 12;
  localparam int SIDE_W = 1 + 3 * COORD_W + 3 * CHAN_W;
  localparam int SUM_W  = COORD_W + 3;
  localparam logic signed [NUM_W-1:0] ONE  = NUM_W'(1) << COORD_FRAC_BITS;
  localparam logic signed [SUM_W-1:0] CMAX = SUM_W'(2 ** (COORD_W - 1) - 1);
  localparam logic signed [SUM_W-1:0] CMIN = -SUM_W'(2 ** (COORD_W - 1));
  localparam logic signed [SUM_W-1:0] HMAX = SUM_W'(2 ** CHAN_W - 1);

  // exact rational parameter n/d, d > 0
  typedef struct packed {
    logic signed [NUM_W-1:0] n;
    logic [DEN_W-1:0]        d;
  } frac_t;

  // values carried alongside the bound search
  typedef struct packed {
    logic                    rej;
    logic [2:0][COORD_W-1:0] s;
    logic [2:0][DIFF_W-1:0]  dv;
    logic [2:0][CHAN_W-1:0]  ca;
    logic [2:0][CHAN_W:0]    cd;
  } carry_t;

  function automatic logic signed [PROD_W-1:0] cross_mul(
    input logic signed [NUM_W-1:0] n, input logic [DEN_W-1:0] d);
    return n * $signed({1'b0, d});
  endfunction

  function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] r;
    r = (v > CMAX) ? CMAX : ((v < CMIN) ? CMIN : v);
    return r[COORD_W-1:0];
  endfunction

  function automatic logic [CHAN_W-1:0] sat_chan(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] r;
    r = (v > HMAX) ? HMAX : ((v < 0) ? '0 : v);
    return r[CHAN_W-1:0];
  endfunction

  assign busy = 1'b0;

  // ---------------- stage 1: face bounds per axis ----------------
  carry_t c1_nxt, c1_r;
  frac_t  ent1_nxt [3], lvg1_nxt [3], ent1_r [3], lvg1_r [3];
  logic   v1_r;

  always_comb begin
    logic signed [COORD_W-1:0] s, e;
    logic signed [NUM_W-1:0]   sn, ne, nl;
    logic signed [DIFF_W-1:0]  dv;
    logic [DEN_W-1:0]          dm;
    logic                      dz, pos;
    logic [CHAN_W-1:0]         ca, cb;
    c1_nxt     = '0;
    c1_nxt.rej = 1'b0;
    for (int i = 0; i < 3; i++) begin
      unique case (i)
        0: begin s = in_req.start_x; e = in_req.end_x; end
        1: begin s = in_req.start_y; e = in_req.end_y; end
        default: begin s = in_req.start_z; e = in_req.end_z; end
      endcase
      sn  = NUM_W'(s);
      dv  = DIFF_W'(e) - DIFF_W'(s);
      dz  = (dv == '0);
      pos = !dv[DIFF_W-1] && !dz;
      dm  = dv[DIFF_W-1] ? DEN_W'(-dv) : DEN_W'(dv);
      ne  = pos ? (-ONE - sn) : (sn - ONE);
      nl  = pos ? (ONE - sn) : (ONE + sn);
      // entering bounds at or below zero, or on an axis with no motion, fold into 0/1
      if (dz || ne <= 0) begin
        ent1_nxt[i].n = '0;
        ent1_nxt[i].d = DEN_W'(1);
      end else begin
        ent1_nxt[i].n = ne;
        ent1_nxt[i].d = dm;
      end
      // leaving bounds at or above one, or on an axis with no motion, fold into 1/1
      if (dz || nl >= $signed(NUM_W'(dm))) begin
        lvg1_nxt[i].n = NUM_W'(1);
        lvg1_nxt[i].d = DEN_W'(1);
      end else begin
        lvg1_nxt[i].n = nl;
        lvg1_nxt[i].d = dm;
      end
      // parallel to a face pair and outside it
      if (dz && (sn < -ONE || sn > ONE)) begin
        c1_nxt.rej = 1'b1;
      end
      c1_nxt.s[i]  = s;
      c1_nxt.dv[i] = dv;
      ca = in_req.start_rgb[RGB_W-1-i*CHAN_W -: CHAN_W];
      cb = in_req.end_rgb[RGB_W-1-i*CHAN_W -: CHAN_W];
      c1_nxt.ca[i] = ca;
      c1_nxt.cd[i] = {1'b0, cb} - {1'b0, ca};
    end
  end

  // ---------------- stage 2: cross products, axis 0 vs 1 ----------------
  carry_t                   c2_r;
  frac_t                    ent2_r [3], lvg2_r [3];
  logic signed [PROD_W-1:0] pe2_r [2], pl2_r [2];
  logic                     v2_r;

  // ---------------- stage 3: select ----------------
  carry_t c3_r;
  frac_t  ent3_nxt [2], lvg3_nxt [2], ent3_r [2], lvg3_r [2];
  logic   v3_r;

  always_comb begin
    ent3_nxt[0] = (pe2_r[1] > pe2_r[0]) ? ent2_r[1] : ent2_r[0];
    lvg3_nxt[0] = (pl2_r[1] < pl2_r[0]) ? lvg2_r[1] : lvg2_r[0];
    ent3_nxt[1] = ent2_r[2];
    lvg3_nxt[1] = lvg2_r[2];
  end

  // ---------------- stage 4: cross products against axis 2 ----------------
  carry_t                   c4_r;
  frac_t                    ent4_r [2], lvg4_r [2];
  logic signed [PROD_W-1:0] pe4_r [2], pl4_r [2];
  logic                     v4_r;

  // ---------------- stage 5: final entering / leaving ----------------
  carry_t c5_r;
  frac_t  te5_nxt, tl5_nxt, te5_r, tl5_r;
  logic   v5_r;

  assign te5_nxt = (pe4_r[1] > pe4_r[0]) ? ent4_r[1] : ent4_r[0];
  assign tl5_nxt = (pl4_r[1] < pl4_r[0]) ? lvg4_r[1] : lvg4_r[0];

  // ---------------- stage 6: visibility and lerp products ----------------
  carry_t                   c6_r;
  frac_t                    te6_r, tl6_r;
  logic signed [PROD_W-1:0] pv6_r [2];
  logic signed [LERP_W-1:0] lp6_nxt [LANES], lp6_r [LANES];
  logic                     v6_r;

  always_comb begin
    logic signed [DIFF_W-1:0] cdx;
    for (int i = 0; i < 3; i++) begin
      cdx            = DIFF_W'($signed(c5_r.cd[i]));
      lp6_nxt[i]     = $signed(c5_r.dv[i]) * te5_r.n;
      lp6_nxt[3 + i] = $signed(c5_r.dv[i]) * tl5_r.n;
      lp6_nxt[6 + i] = cdx * te5_r.n;
      lp6_nxt[9 + i] = cdx * tl5_r.n;
    end
  end

  // ---------------- stage 7: divider operands ----------------
  logic signed [DIVX_W-1:0] x7_nxt [LANES], x7_r [LANES];
  logic [DIVY_W-1:0]        y7_nxt [LANES], y7_r [LANES];
  logic [SIDE_W-1:0]        side7_nxt, side7_r;
  logic                     v7_r;

  always_comb begin
    logic [DEN_W-1:0] d;
    logic             vis;
    for (int l = 0; l < LANES; l++) begin
      // start lanes use the entering parameter, end lanes the leaving one
      d         = (l < 3 || (l >= 6 && l < 9)) ? te6_r.d : tl6_r.d;
      x7_nxt[l] = (DIVX_W'(lp6_r[l]) <<< 1) + DIVX_W'(d);
      y7_nxt[l] = {d, 1'b0};
    end
    vis       = !c6_r.rej && !(pv6_r[0] > pv6_r[1]);
    side7_nxt = {vis, c6_r.s, c6_r.ca};
  end

  // payload registers of the front stages
  always_ff @(posedge clk) begin
    c1_r <= c1_nxt;
    for (int i = 0; i < 3; i++) begin
      ent1_r[i] <= ent1_nxt[i];
      lvg1_r[i] <= lvg1_nxt[i];
    end
    c2_r     <= c1_r;
    ent2_r   <= ent1_r;
    lvg2_r   <= lvg1_r;
    pe2_r[0] <= cross_mul(ent1_r[0].n, ent1_r[1].d);
    pe2_r[1] <= cross_mul(ent1_r[1].n, ent1_r[0].d);
    pl2_r[0] <= cross_mul(lvg1_r[0].n, lvg1_r[1].d);
    pl2_r[1] <= cross_mul(lvg1_r[1].n, lvg1_r[0].d);
    c3_r     <= c2_r;
    ent3_r   <= ent3_nxt;
    lvg3_r   <= lvg3_nxt;
    c4_r     <= c3_r;
    ent4_r   <= ent3_r;
    lvg4_r   <= lvg3_r;
    pe4_r[0] <= cross_mul(ent3_r[0].n, ent3_r[1].d);
    pe4_r[1] <= cross_mul(ent3_r[1].n, ent3_r[0].d);
    pl4_r[0] <= cross_mul(lvg3_r[0].n, lvg3_r[1].d);
    pl4_r[1] <= cross_mul(lvg3_r[1].n, lvg3_r[0].d);
    c5_r     <= c4_r;
    te5_r    <= te5_nxt;
    tl5_r    <= tl5_nxt;
    c6_r     <= c5_r;
    te6_r    <= te5_r;
    tl6_r    <= tl5_r;
    pv6_r[0] <= cross_mul(te5_r.n, tl5_r.d);
    pv6_r[1] <= cross_mul(tl5_r.n, te5_r.d);
    lp6_r    <= lp6_nxt;
    x7_r     <= x7_nxt;
    y7_r     <= y7_nxt;
    side7_r  <= side7_nxt;
  end

  // ---------------- divider ----------------
  logic signed [QUO_W:0] dq [LANES];
  logic [SIDE_W-1:0]     dside;
  logic                  dvld;

  scuc_div_pipe #(
    .LANES  (LANES),
    .X_W    (DIVX_W),
    .Y_W    (DIVY_W),
    .Q_W    (QUO_W),
    .STEPS  (DIV_STEPS),
    .SIDE_W (SIDE_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v7_r),
    .in_x      (x7_r),
    .in_y      (y7_r),
    .in_side   (side7_r),
    .out_valid (dvld),
    .out_q     (dq),
    .out_side  (dside)
  );

  // ---------------- output: add base, saturate, blank hidden ----------------
  seg_out_t res_nxt, res_r;
  logic     out_valid_r;

  always_comb begin
    logic                    vis;
    logic [2:0][COORD_W-1:0] bs;
    logic [2:0][CHAN_W-1:0]  ba;
    logic signed [COORD_W-1:0] cs [3], ce [3];
    logic [CHAN_W-1:0]       hs [3], he [3];
    {vis, bs, ba} = dside;
    for (int i = 0; i < 3; i++) begin
      cs[i] = sat_coord(SUM_W'($signed(bs[i])) + SUM_W'(dq[i]));
      ce[i] = sat_coord(SUM_W'($signed(bs[i])) + SUM_W'(dq[3 + i]));
      hs[i] = sat_chan(SUM_W'(ba[i]) + SUM_W'(dq[6 + i]));
      he[i] = sat_chan(SUM_W'(ba[i]) + SUM_W'(dq[9 + i]));
    end
    res_nxt = '0;
    if (vis) begin
      res_nxt.seen           = 1'b1;
      res_nxt.clip_start_x   = cs[0];
      res_nxt.clip_start_y   = cs[1];
      res_nxt.clip_start_z   = cs[2];
      res_nxt.clip_end_x     = ce[0];
      res_nxt.clip_end_y     = ce[1];
      res_nxt.clip_end_z     = ce[2];
      res_nxt.clip_start_rgb = {hs[0], hs[1], hs[2]};
      res_nxt.clip_end_rgb   = {he[0], he[1], he[2]};
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  // stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      v6_r        <= 1'b0;
      v7_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= start && !busy;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      v5_r        <= v4_r;
      v6_r        <= v5_r;
      v7_r        <= v6_r;
      out_valid_r <= dvld;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = res_r;

endmodule

`default_nettype wire

// ===== rtl/scuc_checker.sv =====
`default_nettype none

`include "segment_clip_unit_cube_unit_defines.svh"

// Port-level checks on the segment clipper.
module scuc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input scuc_pkg::seg_out_t out_res
);

  import scuc_pkg::*;

  // fully pipelined: never refuses a request
  `SCUC_ASSERT_ALWAYS(a_never_busy, clk, rst_n, !busy)

  // every request yields exactly one result after the fixed latency
  `SCUC_ASSERT_IMPL(a_lat_fwd, clk, rst_n, start && !busy, ##PIPE_LAT out_valid)
  `SCUC_ASSERT_IMPL(a_lat_back, clk, rst_n, out_valid, $past(start && !busy, PIPE_LAT))

  // hidden segments come out blank
  `SCUC_ASSERT_IMPL(a_hidden_zero, clk, rst_n, out_valid && !out_res.seen, out_res == '0)

endmodule

bind segment_clip_unit_cube_unit scuc_checker u_scuc_checker (.*);

`default_nettype wire
